### design/windowed_moving_average_assert.svh
// Assertion macros shared by the windowed moving average RTL.
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wma_pkg.sv
// Shared types, constants and register codes of the windowed moving average.
package wma_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int DEFAULT_MAX_WINDOW = 64;
    localparam int MAX_RESULTS        = 32;
    localparam int RESULT_CNT_BITS    = $clog2(MAX_RESULTS + 1);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd1;

    localparam logic MODE_TRIANGULAR  = 1'b0;
    localparam logic MODE_RECTANGULAR = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] LENGTH_RESET = 7'd24;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          last_out;
    } out_item_t;

endpackage

### design/wma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/wma_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_BITS.
module wma_div #(
    parameter int NUM_BITS = 30,
    parameter int DEN_BITS = 14,
    parameter int QUO_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic                done,
    output logic [QUO_BITS-1:0] quo
);

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] shf_reg, shf_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   cand;
    logic                ge;

    // Numerator bits shift out of the top of shf while quotient bits enter below.
    assign cand = {rem_reg, shf_reg[QUO_BITS-1]};
    assign ge   = cand >= {1'b0, den};

    always_comb begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            // High part stays below den because the quotient fits QUO_BITS.
            rem_next = DEN_BITS'(num >> QUO_BITS);
            shf_next = num[QUO_BITS-1:0];
            cnt_next = CNT_BITS'(QUO_BITS);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? DEN_BITS'(cand - {1'b0, den}) : DEN_BITS'(cand);
            shf_next  = {shf_reg[QUO_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quo  = shf_reg;

endmodule

### design/windowed_moving_average.sv
// Top level: centered weighted moving average with sequencer and MAC.
//
// Usage:
//   s_valid/s_ready/s_data take one sample (with its last flag) per transfer.
//   m_valid/m_ready/m_data deliver filtered values, zero or more per sample;
//   last_out marks the final value of a sequence after a last sample.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write window_mode (index 0) and
//   window_length (index 1); cfg_ready is always high, write only when idle.
// Timing:
//   A sample is accepted, then the sequencer checks what is due. For each
//   filtered value the taps go one per cycle through the RAM read and
//   multiply-accumulate pipeline, which drains (sooner when the last taps
//   fall off the sequence) before the shared bit-serial divider starts; the
//   value is then handed to the output register and the check runs again.
//   s_ready stays low until every value due for the sample is handed over.
// Reset: clears the sequence counters, valid flags and configuration; the
//   history RAM is not cleared, as only current-sequence entries are read.
// Stall: a waiting result sits in the output register; the next result is
//   computed meanwhile and held in the divider until the register frees up.
`include "windowed_moving_average_assert.svh"

module windowed_moving_average #(
    parameter int MAX_WINDOW = wma_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wma_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output wma_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wma_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import wma_pkg::*;

    localparam int AW        = $clog2(MAX_WINDOW);
    localparam int LEN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int DW        = LEN_BITS + 2;
    localparam int WSUM_BITS = 2 * LEN_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + LEN_BITS + 1;
    localparam int ACC_BITS  = SAMPLE_BITS + WSUM_BITS + 1;
    localparam int NUM_BITS  = SAMPLE_BITS + WSUM_BITS;
    localparam logic [RESULT_CNT_BITS-1:0] N_CAP = RESULT_CNT_BITS'(MAX_RESULTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Configuration
    logic                mode_reg;
    logic [CFG_DATA_BITS-1:0] length_reg;

    // Sequencer state
    logic [2:0]                 state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next, head_inc;
    logic [LEN_BITS-1:0]        seen_reg, seen_next;
    logic [LEN_BITS-1:0]        outpos_reg, outpos_next;
    logic                       fin_reg, fin_next;
    logic [RESULT_CNT_BITS-1:0] n_reg, n_next;
    logic [LEN_BITS-1:0]        back_reg, back_next;
    logic [LEN_BITS-1:0]        k_reg, k_next;
    logic                       last_pend_reg, last_pend_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;

    // MAC pipeline
    logic                         p1_reg, p2_reg;
    logic [LEN_BITS-1:0]          w1_reg, w2_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [WSUM_BITS-1:0]         wsum_reg, wsum_next;

    // Output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // Derived values
    logic [LEN_BITS-1:0] len, half, lag, pending, weight;
    logic                accept, issue, in_range, mac_done, out_free, stop;
    logic signed [DW-1:0] d;
    logic [AW:0]          addr_sum;
    logic [AW-1:0]        rd_addr;
    logic [SAMPLE_BITS-1:0] ram_q;
    logic [ACC_BITS-1:0]  mag;
    logic [NUM_BITS-1:0]  div_num;
    logic                 div_start, div_busy, div_done;
    logic [SAMPLE_BITS-1:0] div_quo;

    // Clamp the length register to 1 .. MAX_WINDOW.
    always_comb begin
        if (length_reg == '0) begin
            len = LEN_BITS'(1);
        end else if (int'(length_reg) > MAX_WINDOW) begin
            len = LEN_BITS'(MAX_WINDOW);
        end else begin
            len = LEN_BITS'(length_reg);
        end
    end

    assign half    = len >> 1;
    assign lag     = len - half - 1'b1;
    assign pending = seen_reg - outpos_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign head_inc  = (head_reg == AW'(MAX_WINDOW - 1)) ? '0 : head_reg + 1'b1;

    // Tap k reads the sample 'back + half - k' positions behind the newest.
    assign issue    = (state_reg == ST_MAC) && (k_reg < len);
    assign d        = $signed({2'b00, back_reg}) + $signed({2'b00, half})
                      - $signed({2'b00, k_reg});
    assign in_range = !d[DW-1] && (d[DW-2:0] < {1'b0, seen_reg});
    assign addr_sum = (AW+1)'(head_reg) + (AW+1)'(MAX_WINDOW) - (AW+1)'(d[DW-2:0]);
    assign rd_addr  = (addr_sum >= (AW+1)'(MAX_WINDOW))
                      ? AW'(addr_sum - (AW+1)'(MAX_WINDOW)) : AW'(addr_sum);

    always_comb begin
        if (mode_reg == MODE_RECTANGULAR) begin
            weight = LEN_BITS'(1);
        end else if ({k_reg, 1'b0} < {1'b0, len}) begin
            weight = k_reg + 1'b1;
        end else begin
            weight = len - k_reg;
        end
    end

    assign mac_done  = (k_reg == len) && !p1_reg && !p2_reg;
    assign div_start = (state_reg == ST_MAC) && mac_done;
    assign out_free  = !m_valid_reg || m_ready;

    // Round to nearest, ties away from zero: divide |acc| + wsum/2 by wsum.
    assign mag     = acc_reg[ACC_BITS-1] ? ACC_BITS'(-acc_reg) : ACC_BITS'(acc_reg);
    assign div_num = NUM_BITS'(mag) + NUM_BITS'(wsum_reg >> 1);

    assign stop = (pending == '0) || (n_reg == N_CAP) || (!fin_reg && (pending <= lag));

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        seen_next      = seen_reg;
        outpos_next    = outpos_reg;
        fin_next       = fin_reg;
        n_next         = n_reg;
        back_next      = back_reg;
        k_next         = k_reg;
        last_pend_next = last_pend_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        acc_next       = acc_reg;
        wsum_next      = wsum_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    head_next = head_inc;
                    // Saturated history drops its oldest sample.
                    if (seen_reg < LEN_BITS'(MAX_WINDOW)) begin
                        seen_next = seen_reg + 1'b1;
                    end else if (outpos_reg != '0) begin
                        outpos_next = outpos_reg - 1'b1;
                    end
                    fin_next   = s_data.last;
                    n_next     = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stop) begin
                    if (fin_reg) begin
                        seen_next   = '0;
                        outpos_next = '0;
                    end
                    state_next = ST_IDLE;
                end else begin
                    back_next      = pending - 1'b1;
                    k_next         = '0;
                    acc_next       = '0;
                    wsum_next      = '0;
                    last_pend_next = fin_reg && ((pending == LEN_BITS'(1))
                                                 || (n_reg == N_CAP - 1'b1));
                    state_next     = ST_MAC;
                end
            end
            ST_MAC: begin
                if (issue) begin
                    k_next = k_reg + 1'b1;
                end
                if (p2_reg) begin
                    acc_next  = acc_reg + ACC_BITS'(prod_reg);
                    wsum_next = wsum_reg + WSUM_BITS'(w2_reg);
                end
                if (mac_done) begin
                    neg_next   = acc_reg[ACC_BITS-1];
                    zero_next  = (wsum_reg == '0);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold the quotient until the output register frees up.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (zero_reg) begin
                        m_data_next.filtered = '0;
                    end else if (neg_reg) begin
                        m_data_next.filtered = -div_quo;
                    end else begin
                        m_data_next.filtered = div_quo;
                    end
                    m_data_next.last_out = last_pend_reg;
                    outpos_next = outpos_reg + 1'b1;
                    n_next      = n_reg + 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            seen_reg    <= '0;
            outpos_reg  <= '0;
            n_reg       <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_TRIANGULAR;
            length_reg  <= LENGTH_RESET;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            seen_reg    <= seen_next;
            outpos_reg  <= outpos_next;
            n_reg       <= n_next;
            p1_reg      <= issue && in_range;
            p2_reg      <= p1_reg;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_WINDOW_MODE:   mode_reg   <= cfg_data[0];
                    CFG_WINDOW_LENGTH: length_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        fin_reg       <= fin_next;
        back_reg      <= back_next;
        k_reg         <= k_next;
        last_pend_reg <= last_pend_next;
        neg_reg       <= neg_next;
        zero_reg      <= zero_next;
        acc_reg       <= acc_next;
        wsum_reg      <= wsum_next;
        m_data_reg    <= m_data_next;
        w1_reg        <= weight;
        w2_reg        <= w1_reg;
        prod_reg      <= $signed(ram_q) * $signed({1'b0, w1_reg});
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    wma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .aclk  (aclk),
        .we    (accept),
        .waddr (head_inc),
        .wdata (s_data.sample),
        .re    (issue && in_range),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    wma_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (WSUM_BITS),
        .QUO_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (wsum_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    `WMA_ASSERT_SAME(a_pos_within_seen, 1'b1, outpos_reg <= seen_reg, "output position past kept samples")
    `WMA_ASSERT_SAME(a_result_cap, state_reg == ST_EMIT, n_reg < N_CAP, "result cap exceeded")
    `WMA_ASSERT_SAME(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
    `WMA_ASSERT_NEXT(a_busy_after_accept, accept, state_reg == ST_CHECK, "sample transfer did not start a check")

endmodule
